[rtl/cmc_pkg.sv]
// Shared types and constants for the circular merge cost block.
`timescale 1ns / 1ps
`default_nettype none
package cmc_pkg;
  localparam int DEF_MAX_PILES  = 32;
  localparam int DEF_VALUE_BITS = 16;
  localparam int IN_BITS        = 16;
  localparam int COST_BITS      = 26;
  localparam int QUEUE_DEPTH    = 4;
  localparam logic [63:0] COST_LIMIT = 64'd67108863;

  typedef struct packed {
    logic [IN_BITS-1:0] value;
    logic               last;
  } word_t;

  typedef struct packed {
    logic  valid;
    word_t word;
  } qhead_t;
endpackage
`default_nettype wire

[rtl/cmc_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module cmc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire                      clk,
  input  wire                      we,
  input  wire [$clog2(DEPTH)-1:0]  waddr,
  input  wire [WIDTH-1:0]          wdata,
  input  wire [$clog2(DEPTH)-1:0]  raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

[rtl/cmc_front.sv]
// Input side: accepts pile words, masks the value, queues them for the solver.
`timescale 1ns / 1ps
`default_nettype none
module cmc_front import cmc_pkg::*; #(
  parameter int VALUE_BITS = DEF_VALUE_BITS
) (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire                        in_valid,
  output logic                       in_stall,
  input  wire [IN_BITS-1:0]          in_pile_value,
  input  wire                        in_last_pile,
  output qhead_t                     q_head,
  input  wire                        q_pop,
  output logic [$clog2(QUEUE_DEPTH+1)-1:0] q_level
);
  localparam int VB = (VALUE_BITS < IN_BITS) ? VALUE_BITS : IN_BITS;
  localparam int PTRW = $clog2(QUEUE_DEPTH);
  localparam int LVLW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [IN_BITS-1:0] VMASK = IN_BITS'((65'd1 << VB) - 65'd1);

  word_t            q_r [QUEUE_DEPTH];
  logic [PTRW-1:0]  wp_r, wp_nxt, rp_r, rp_nxt;
  logic [LVLW-1:0]  cnt_r, cnt_nxt;
  logic             push, pop;

  assign in_stall = (cnt_r == LVLW'(QUEUE_DEPTH));
  assign push     = in_valid && !in_stall;
  assign pop      = q_pop && (cnt_r != '0);
  assign q_head.valid = (cnt_r != '0);
  assign q_head.word  = q_r[rp_r];
  assign q_level  = cnt_r;

  always_comb begin
    wp_nxt  = push ? PTRW'((32'(wp_r) + 1) % QUEUE_DEPTH) : wp_r;
    rp_nxt  = pop  ? PTRW'((32'(rp_r) + 1) % QUEUE_DEPTH) : rp_r;
    cnt_nxt = cnt_r + LVLW'(push) - LVLW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push) begin
      q_r[wp_r].value <= in_pile_value & VMASK;
      q_r[wp_r].last  <= in_last_pile;
    end
  end
endmodule
`default_nettype wire

[rtl/cmc_back.sv]
// Solver: builds prefix sums and runs the circular interval merge recurrence.
`timescale 1ns / 1ps
`default_nettype none
module cmc_back import cmc_pkg::*; #(
  parameter int MAX_PILES  = DEF_MAX_PILES,
  parameter int VALUE_BITS = DEF_VALUE_BITS
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire qhead_t                  q_head,
  output logic                         q_pop,
  output logic                         out_valid,
  input  wire                          out_stall,
  output logic [COST_BITS-1:0]         out_max_cost,
  output logic [COST_BITS-1:0]         out_min_cost,
  output logic                         out_too_many,
  output logic [$clog2(MAX_PILES+1)-1:0] pile_count
);
  localparam int VB   = (VALUE_BITS < IN_BITS) ? VALUE_BITS : IN_BITS;
  localparam int NW   = $clog2(MAX_PILES + 1);
  localparam int IW   = (MAX_PILES > 1) ? $clog2(MAX_PILES) : 1;
  localparam int PW   = VB + NW;
  localparam int CW   = VB + 2 * NW;
  localparam int TAW  = 2 * IW;

  localparam logic [3:0] ST_COL  = 4'd0;
  localparam logic [3:0] ST_PA   = 4'd1;
  localparam logic [3:0] ST_PB   = 4'd2;
  localparam logic [3:0] ST_PW   = 4'd3;
  localparam logic [3:0] ST_SL   = 4'd4;
  localparam logic [3:0] ST_SR   = 4'd5;
  localparam logic [3:0] ST_SC   = 4'd6;
  localparam logic [3:0] ST_WR   = 4'd7;
  localparam logic [3:0] ST_DONE = 4'd8;

  logic [3:0]    state_r, state_nxt;
  logic [NW-1:0] cnt_r, cnt_nxt, len_r, len_nxt, i_r, i_nxt, l_r, l_nxt;
  logic [PW-1:0] acc_r, acc_nxt, pn_r, pn_nxt, pi_r, pi_nxt, w_r, w_nxt;
  logic          ovf_r, ovf_nxt, wrap_r, wrap_nxt;
  logic [CW-1:0] lmax_r, lmax_nxt, lmin_r, lmin_nxt;
  logic [CW-1:0] bmax_r, bmax_nxt, bmin_r, bmin_nxt;
  logic [CW-1:0] hi_r, hi_nxt, lo_r, lo_nxt;
  logic          ov_r, ov_nxt;
  logic [COST_BITS-1:0] omax_r, omax_nxt, omin_r, omin_nxt;
  logic          otm_r, otm_nxt;

  logic          p_we;
  logic [NW-1:0] p_waddr, p_raddr;
  logic [PW-1:0] p_wdata, p_rdata;
  logic          t_we;
  logic [TAW-1:0] t_waddr, t_raddr;
  logic [CW-1:0] tmax_rd, tmin_rd;

  logic [NW:0]   ends, rsum;
  logic [NW-1:0] eidx, rs;
  logic [PW:0]   wsum;
  logic [CW-1:0] rmax, rmin, amax, amin;
  logic [NW-1:0] lm1, rm1;

  cmc_ram #(.WIDTH(PW), .DEPTH(2 ** NW)) u_prefix (
    .clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
    .raddr(p_raddr), .rdata(p_rdata)
  );
  cmc_ram #(.WIDTH(CW), .DEPTH(2 ** TAW)) u_max (
    .clk(clk), .we(t_we), .waddr(t_waddr), .wdata(bmax_r),
    .raddr(t_raddr), .rdata(tmax_rd)
  );
  cmc_ram #(.WIDTH(CW), .DEPTH(2 ** TAW)) u_min (
    .clk(clk), .we(t_we), .waddr(t_waddr), .wdata(bmin_r),
    .raddr(t_raddr), .rdata(tmin_rd)
  );

  assign out_valid    = ov_r;
  assign out_max_cost = omax_r;
  assign out_min_cost = omin_r;
  assign out_too_many = otm_r;
  assign pile_count   = cnt_r;

  always_comb begin
    ends = {1'b0, i_r} + {1'b0, len_r};
    eidx = (ends > {1'b0, cnt_r}) ? NW'(ends - {1'b0, cnt_r}) : NW'(ends);
    rsum = {1'b0, i_r} + {1'b0, l_r};
    rs   = (rsum >= {1'b0, cnt_r}) ? NW'(rsum - {1'b0, cnt_r}) : NW'(rsum);
    lm1  = l_r - NW'(1);
    rm1  = len_r - l_r - NW'(1);
    wsum = {1'b0, p_rdata} + (wrap_r ? {1'b0, pn_r} : '0) - {1'b0, pi_r};
    rmax = (rm1 == '0) ? '0 : tmax_rd;
    rmin = (rm1 == '0) ? '0 : tmin_rd;
    amax = lmax_r + rmax + CW'(w_r);
    amin = lmin_r + rmin + CW'(w_r);
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r;   len_nxt = len_r;   i_nxt = i_r;     l_nxt = l_r;
    acc_nxt = acc_r;   pn_nxt = pn_r;     pi_nxt = pi_r;   w_nxt = w_r;
    ovf_nxt = ovf_r;   wrap_nxt = wrap_r;
    lmax_nxt = lmax_r; lmin_nxt = lmin_r; bmax_nxt = bmax_r; bmin_nxt = bmin_r;
    hi_nxt = hi_r;     lo_nxt = lo_r;
    omax_nxt = omax_r; omin_nxt = omin_r; otm_nxt = otm_r;
    ov_nxt = ov_r && out_stall;
    q_pop = 1'b0;
    p_we = 1'b0; p_waddr = cnt_r + NW'(1); p_wdata = acc_r + PW'(q_head.word.value);
    p_raddr = i_r;
    t_we = 1'b0;
    t_waddr = {i_r[IW-1:0], rm1[IW-1:0]};
    t_raddr = {i_r[IW-1:0], lm1[IW-1:0]};
    case (state_r)
      ST_COL: begin
        if (q_head.valid) begin
          q_pop = 1'b1;
          if (cnt_r < NW'(MAX_PILES)) begin
            p_we    = 1'b1;
            acc_nxt = p_wdata;
            cnt_nxt = cnt_r + NW'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
          if (q_head.word.last) begin
            pn_nxt  = acc_nxt;
            hi_nxt  = '0;
            lo_nxt  = '0;
            len_nxt = NW'(2);
            i_nxt   = '0;
            state_nxt = (cnt_nxt == NW'(1)) ? ST_DONE : ST_PA;
          end
        end
      end
      ST_PA: begin
        p_raddr   = i_r;
        state_nxt = ST_PB;
      end
      ST_PB: begin
        pi_nxt    = (i_r == '0) ? '0 : p_rdata;
        p_raddr   = eidx;
        wrap_nxt  = ends > {1'b0, cnt_r};
        state_nxt = ST_PW;
      end
      ST_PW: begin
        w_nxt     = PW'(wsum);
        l_nxt     = NW'(1);
        state_nxt = ST_SL;
      end
      ST_SL: begin
        t_raddr   = {i_r[IW-1:0], lm1[IW-1:0]};
        state_nxt = ST_SR;
      end
      ST_SR: begin
        lmax_nxt  = (l_r == NW'(1)) ? '0 : tmax_rd;
        lmin_nxt  = (l_r == NW'(1)) ? '0 : tmin_rd;
        t_raddr   = {rs[IW-1:0], rm1[IW-1:0]};
        state_nxt = ST_SC;
      end
      ST_SC: begin
        if (l_r == NW'(1) || amax > bmax_r) bmax_nxt = amax;
        if (l_r == NW'(1) || amin < bmin_r) bmin_nxt = amin;
        if (l_r == len_r - NW'(1)) begin
          state_nxt = ST_WR;
        end else begin
          l_nxt     = l_r + NW'(1);
          state_nxt = ST_SL;
        end
      end
      ST_WR: begin
        t_we    = 1'b1;
        t_waddr = {i_r[IW-1:0], IW'(len_r - NW'(1))};
        if (len_r == cnt_r) begin
          if (i_r == '0 || bmax_r > hi_r) hi_nxt = bmax_r;
          if (i_r == '0 || bmin_r < lo_r) lo_nxt = bmin_r;
        end
        if (i_r == cnt_r - NW'(1)) begin
          i_nxt = '0;
          if (len_r == cnt_r) begin
            state_nxt = ST_DONE;
          end else begin
            len_nxt   = len_r + NW'(1);
            state_nxt = ST_PA;
          end
        end else begin
          i_nxt     = i_r + NW'(1);
          state_nxt = ST_PA;
        end
      end
      ST_DONE: begin
        if (!ov_r || !out_stall) begin
          ov_nxt   = 1'b1;
          omax_nxt = ({{(64-CW){1'b0}}, hi_r} > COST_LIMIT) ?
                     COST_BITS'(COST_LIMIT) : COST_BITS'(hi_r);
          omin_nxt = ({{(64-CW){1'b0}}, lo_r} > COST_LIMIT) ?
                     COST_BITS'(COST_LIMIT) : COST_BITS'(lo_r);
          otm_nxt  = ovf_r;
          cnt_nxt  = '0;
          acc_nxt  = '0;
          ovf_nxt  = 1'b0;
          state_nxt = ST_COL;
        end
      end
      default: begin
        state_nxt = ST_COL;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_COL;
      cnt_r   <= '0;
      acc_r   <= '0;
      ovf_r   <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      acc_r   <= acc_nxt;
      ovf_r   <= ovf_nxt;
      ov_r    <= ov_nxt;
    end
    len_r <= len_nxt;   i_r <= i_nxt;       l_r <= l_nxt;
    pn_r <= pn_nxt;     pi_r <= pi_nxt;     w_r <= w_nxt;   wrap_r <= wrap_nxt;
    lmax_r <= lmax_nxt; lmin_r <= lmin_nxt; bmax_r <= bmax_nxt; bmin_r <= bmin_nxt;
    hi_r <= hi_nxt;     lo_r <= lo_nxt;
    omax_r <= omax_nxt; omin_r <= omin_nxt; otm_r <= otm_nxt;
  end
endmodule
`default_nettype wire

[rtl/circular_merge_cost_dp_core.sv]
// Circular stone-merging cost engine: top level.
// Input channel: one pile word per item (in_pile_value, in_last_pile) with
// in_valid / in_stall. Words enter a 4-deep queue; the solver drains it at
// one word per cycle while collecting, adding each pile to a prefix-sum
// RAM. Piles past MAX_PILES are dropped and flagged in out_too_many.
// A word with in_last_pile starts the solve on the stored circle of n piles.
// The recurrence walks every interval length 2..n and every start; each
// interval reads prefix sums (PA, PB, PW), visits each split point (SL, SR,
// SC) and writes the tables (WR), paced by the cost tables' single read port.
// Words keep entering the queue during the solve until it fills.
// One result word carries out_max_cost, out_min_cost (saturated to 26 bits)
// and out_too_many. It sits in an output register until taken; while
// out_stall is high the next result waits and the solver holds.
// Reset (rst_n low, synchronous) empties the queue, clears the pile count,
// the overflow flag and out_valid. Table contents need no clearing.
`timescale 1ns / 1ps
`default_nettype none
module circular_merge_cost_dp_core import cmc_pkg::*; #(
  parameter int MAX_PILES  = DEF_MAX_PILES,
  parameter int VALUE_BITS = DEF_VALUE_BITS
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_stall,
  input  wire [IN_BITS-1:0]    in_pile_value,
  input  wire                  in_last_pile,
  output logic                 out_valid,
  input  wire                  out_stall,
  output logic [COST_BITS-1:0] out_max_cost,
  output logic [COST_BITS-1:0] out_min_cost,
  output logic                 out_too_many
);
  qhead_t                              q_head;
  logic                                q_pop;
  logic [$clog2(QUEUE_DEPTH+1)-1:0]    q_level;
  logic [$clog2(MAX_PILES+1)-1:0]      pile_count;

  cmc_front #(.VALUE_BITS(VALUE_BITS)) u_front (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_pile_value(in_pile_value), .in_last_pile(in_last_pile),
    .q_head(q_head), .q_pop(q_pop), .q_level(q_level)
  );

  cmc_back #(.MAX_PILES(MAX_PILES), .VALUE_BITS(VALUE_BITS)) u_back (
    .clk(clk), .rst_n(rst_n),
    .q_head(q_head), .q_pop(q_pop),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_max_cost(out_max_cost), .out_min_cost(out_min_cost),
    .out_too_many(out_too_many), .pile_count(pile_count)
  );

  a_min_le_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_min_cost <= out_max_cost) else $error("min cost above max cost");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(pile_count) <= MAX_PILES) else $error("pile count past limit");

  a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(q_level) <= QUEUE_DEPTH) else $error("queue level past depth");

  a_rst_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall) else $error("not idle after reset");
endmodule
`default_nettype wire

[tb/tb.sv]
// Testbench for circular_merge_cost_dp_core: directed table, random circles, scoreboard.
`timescale 1ns / 1ps
module tb;
  import cmc_pkg::*;

  localparam int MAXP = DEF_MAX_PILES;

  typedef struct {
    logic [IN_BITS-1:0]   value;
    logic                 last;
    bit                   typed;
    logic [COST_BITS-1:0] hi;
    logic [COST_BITS-1:0] lo;
    logic                 over;
  } pile_word_t;

  typedef struct {
    logic [COST_BITS-1:0] hi;
    logic [COST_BITS-1:0] lo;
    logic                 over;
  } costs_t;

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_stall;
  logic [IN_BITS-1:0] in_pile_value = '0;
  logic in_last_pile = 0;
  logic out_valid;
  logic out_stall = 0;
  logic [COST_BITS-1:0] out_max_cost, out_min_cost;
  logic out_too_many;

  pile_word_t pending_words[$];
  pile_word_t cur_word;
  costs_t     costs_due[$];
  bit         fails = 0;
  bit         calm = 0;
  int         in_gap = 0, out_gap = 0;

  longint unsigned circle[MAXP];
  int              circle_len = 0;
  bit              circle_over = 0;
  longint unsigned psum[2*MAXP+1];
  longint unsigned tmax[2*MAXP][2*MAXP];
  longint unsigned tmin[2*MAXP][2*MAXP];

  // single piles, pairs at extremes, small hand-checkable circles
  pile_word_t directed[21] = '{
    '{'0,       1, 1, 0,      0,      0},
    '{'1,       1, 1, 0,      0,      0},
    '{'1,       0, 0, 0,      0,      0},
    '{'1,       1, 1, 131070, 131070, 0},
    '{'0,       0, 0, 0,      0,      0},
    '{'0,       1, 1, 0,      0,      0},
    '{16'd1,    0, 0, 0,      0,      0},
    '{16'd2,    0, 0, 0,      0,      0},
    '{16'd3,    1, 1, 11,     9,      0},
    '{'0,       0, 0, 0,      0,      0},
    '{'0,       0, 0, 0,      0,      0},
    '{'0,       1, 1, 0,      0,      0},
    '{16'hAAAA, 0, 0, 0,      0,      0},
    '{16'h5555, 0, 0, 0,      0,      0},
    '{16'h8001, 0, 0, 0,      0,      0},
    '{16'h7FFE, 1, 0, 0,      0,      0},
    '{16'd4,    0, 0, 0,      0,      0},
    '{16'd9,    0, 0, 0,      0,      0},
    '{16'd6,    0, 0, 0,      0,      0},
    '{16'd1,    0, 0, 0,      0,      0},
    '{16'd7,    1, 0, 0,      0,      0}
  };

  circular_merge_cost_dp_core DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_pile_value(in_pile_value), .in_last_pile(in_last_pile),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_max_cost(out_max_cost), .out_min_cost(out_min_cost),
    .out_too_many(out_too_many)
  );

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  function automatic logic [COST_BITS-1:0] sat_cost(longint unsigned v);
    return (v > COST_LIMIT) ? COST_LIMIT[COST_BITS-1:0] : v[COST_BITS-1:0];
  endfunction

  function automatic costs_t merge_costs();
    costs_t r;
    int n, s, i, j, k, len;
    longint unsigned w, a, b, mx, mn, hi, lo;
    n = circle_len;
    s = 2 * n;
    psum[0] = 0;
    for (i = 0; i < s; i++) begin
      psum[i+1] = psum[i] + circle[i % n];
      tmax[i][i] = 0;
      tmin[i][i] = 0;
    end
    for (len = 2; len <= n; len++) begin
      for (i = 0; i + len <= s; i++) begin
        j = i + len - 1;
        w = psum[j+1] - psum[i];
        mx = 0;
        mn = 0;
        for (k = i; k < j; k++) begin
          a = tmax[i][k] + tmax[k+1][j] + w;
          b = tmin[i][k] + tmin[k+1][j] + w;
          if (k == i || a > mx) mx = a;
          if (k == i || b < mn) mn = b;
        end
        tmax[i][j] = mx;
        tmin[i][j] = mn;
      end
    end
    hi = 0;
    lo = 0;
    for (i = 0; i < n; i++) begin
      if (i == 0 || tmax[i][i+n-1] > hi) hi = tmax[i][i+n-1];
      if (i == 0 || tmin[i][i+n-1] < lo) lo = tmin[i][i+n-1];
    end
    r.hi = sat_cost(hi);
    r.lo = sat_cost(lo);
    r.over = circle_over;
    return r;
  endfunction

  task automatic take_pile(pile_word_t wd);
    costs_t c;
    if (circle_len < MAXP) begin
      circle[circle_len] = wd.value;
      circle_len++;
    end else begin
      circle_over = 1;
    end
    if (wd.last) begin
      c = merge_costs();
      if (wd.typed) begin
        c.hi = wd.hi;
        c.lo = wd.lo;
        c.over = wd.over;
      end
      costs_due = {costs_due, c};
      circle_len = 0;
      circle_over = 0;
    end
  endtask

  task automatic add_word(logic [IN_BITS-1:0] v, logic l);
    pile_word_t wd;
    wd.value = v;
    wd.last = l;
    wd.typed = 0;
    wd.hi = '0;
    wd.lo = '0;
    wd.over = 0;
    pending_words = {pending_words, wd};
  endtask

  function automatic logic [IN_BITS-1:0] rand_pile();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return IN_BITS'($urandom_range(0, 15));
      default: return IN_BITS'($urandom);
    endcase
  endfunction

  // input side
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 0;
    end else begin
      if (in_valid && !in_stall) take_pile(cur_word);
      if (!in_valid || !in_stall) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 0;
        end else if (pending_words.size() > 0) begin
          cur_word = pending_words.pop_front();
          in_pile_value <= cur_word.value;
          in_last_pile <= cur_word.last;
          in_valid <= 1;
          if (!calm && pending_words.size() > 60 && $urandom_range(0, 7) == 0)
            in_gap = $urandom_range(1, 14);
        end else begin
          in_valid <= 0;
        end
      end
    end
  end

  // result side
  always @(posedge clk) begin
    costs_t c;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (costs_due.size() == 0) begin
          $error("unexpected result word: max %0d min %0d too_many %0d",
                 out_max_cost, out_min_cost, out_too_many);
          fails = 1;
        end else begin
          c = costs_due.pop_front();
          if (out_max_cost !== c.hi) begin
            $error("max_cost: expected %0d, got %0d", c.hi, out_max_cost);
            fails = 1;
          end
          if (out_min_cost !== c.lo) begin
            $error("min_cost: expected %0d, got %0d", c.lo, out_min_cost);
            fails = 1;
          end
          if (out_too_many !== c.over) begin
            $error("too_many: expected %0d, got %0d", c.over, out_too_many);
            fails = 1;
          end
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        out_stall <= 1;
      end else if (!calm && pending_words.size() > 60 && $urandom_range(0, 5) == 0) begin
        out_gap = $urandom_range(0, 13);
        out_stall <= 1;
      end else begin
        out_stall <= 0;
      end
    end
  end

  // quiet stretches and the closing part run without idling
  always @(posedge clk) begin
    if ($urandom_range(0, 399) == 0) calm <= ~calm;
  end

  initial begin
    int total, circ, sz, i;
    foreach (directed[d]) pending_words = {pending_words, directed[d]};
    total = pending_words.size();
    circ = 0;
    while (total < 580) begin
      case (circ)
        1: sz = MAXP;
        3: sz = MAXP + 1;
        6: sz = MAXP + 8;
        9: sz = MAXP;
        default: sz = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 16)
                                                  : $urandom_range(1, 8);
      endcase
      for (i = 0; i < sz; i++) begin
        if (circ == 9) add_word('1, i == sz - 1);
        else add_word(rand_pile(), i == sz - 1);
      end
      total += sz;
      circ++;
    end
    repeat (9) @(posedge clk);
    rst_n <= 1;
    wait (pending_words.size() == 0 && !in_valid && costs_due.size() == 0);
    repeat (200) @(posedge clk);
    if (!fails && costs_due.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("RESULT: ERROR");
    $finish;
  end
endmodule
